### rtl/mhpq_pkg.sv
package mhpq_pkg;

	localparam int KEY_W = 32;
	localparam int COUNT_OUT_W = 8;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// what one cell hands to the next cell down the row
	typedef struct packed {
		key_t key;
		logic stay;
	} link_t;

endpackage

### rtl/mhpq_cell.sv
module mhpq_cell
	import mhpq_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW  = 8
) (
	input  logic          clk,
	input  logic          ins_en,
	input  logic          rem_en,
	input  key_t          ins_key,
	input  logic [CW-1:0] count,
	input  link_t         prev,
	input  key_t          next_key,
	output link_t         link
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	key_t key_q;
	key_t key_nxt;
	logic occ;
	logic stay;

	assign occ  = count > IDX_C;
	assign stay = occ && (key_q >= ins_key);

	assign link.key  = key_q;
	assign link.stay = stay;

	always_comb begin
		if (rem_en) begin
			key_nxt = next_key;
		end else if (stay) begin
			key_nxt = key_q;
		end else if (prev.stay) begin
			key_nxt = ins_key;
		end else begin
			key_nxt = prev.key;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en || rem_en) begin
			key_q <= key_nxt;
		end
	end

endmodule

### rtl/max_heap_priority_queue.sv
// result: registered, and valid in the cycle after its request is accepted
// throughput: one request per cycle while the result register is free; each cell of the sorted row updates in parallel
// the result register frees the input side whenever it is empty or being taken
// reset: asynchronous, clears the entry count and the result valid flag
// stored keys are not cleared; only entries below the count are ever read
module max_heap_priority_queue
	import mhpq_pkg::*;
#(
	parameter int CAPACITY = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   opcode,
	input  logic signed [KEY_W-1:0] value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [KEY_W-1:0] removed_value,
	output logic [1:0]             status,
	output logic [COUNT_OUT_W-1:0] entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [CW-1:0] count_q;
	logic          out_valid_q;
	key_t          removed_q;
	status_t       status_q;
	logic [CW-1:0] count_out_q;

	logic accept;
	logic full;
	logic empty;
	logic ins_en;
	logic rem_en;
	status_t status_nxt;
	link_t links [CAPACITY];
	link_t head;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = count_q == CAP_C;
	assign empty    = count_q == '0;
	assign ins_en   = accept && (opcode == OP_INSERT) && !full;
	assign rem_en   = accept && (opcode == OP_REMOVE) && !empty;

	// the row top always keeps its slot, so a new maximum lands in cell 0
	assign head.key  = '0;
	assign head.stay = 1'b1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		mhpq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk      (clk),
			.ins_en   (ins_en),
			.rem_en   (rem_en),
			.ins_key  (value),
			.count    (count_q),
			.prev     ((i == 0) ? head : links[(i == 0) ? 0 : i - 1]),
			.next_key (links[(i == CAPACITY - 1) ? i : i + 1].key),
			.link     (links[i])
		);
	end

	always_comb begin
		if (opcode == OP_INSERT) begin
			status_nxt = full ? ST_FULL : ST_OK;
		end else begin
			status_nxt = empty ? ST_EMPTY : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ins_en) begin
				count_q <= count_q + CW'(1);
			end else if (rem_en) begin
				count_q <= count_q - CW'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			removed_q <= rem_en ? links[0].key : '0;
			status_q  <= status_nxt;
			if (ins_en) begin
				count_out_q <= count_q + CW'(1);
			end else if (rem_en) begin
				count_out_q <= count_q - CW'(1);
			end else begin
				count_out_q <= count_q;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = removed_q;
	assign status        = status_q;
	assign entry_count   = COUNT_OUT_W'(count_out_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ins_en |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the count");

	a_empty_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_REMOVE && empty) |=>
			(out_valid_q && status_q == ST_EMPTY && removed_q == '0))
		else $error("removal from empty queue not refused");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_FULL) |-> count_out_q == CAP_C)
		else $error("full status with count below capacity");

endmodule

### verif/max_heap_priority_queue_tb.sv
module max_heap_priority_queue_tb;
	import mhpq_pkg::*;

	localparam int CAPACITY = 128;

	typedef struct {
		opcode_t op;
		key_t    key;
		bit      hold_until_idle;
		bit      calm;
	} request_t;

	typedef struct {
		key_t                   removed;
		status_t                st;
		logic [COUNT_OUT_W-1:0] count;
	} outcome_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   opcode = 1'b0;
	key_t                   value = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	key_t                   removed_value;
	logic [1:0]             status;
	logic [COUNT_OUT_W-1:0] entry_count;

	request_t op_queue[$];
	outcome_t expected_outcomes[$];
	key_t     heap_keys[1:CAPACITY];
	int       heap_size = 0;
	int       mismatch_count = 0;

	int send_gap = 0;
	bit calm_phase = 1'b0;
	int recv_gap = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int recv_count = 0;

	request_t next_req;
	outcome_t got_exp;

	max_heap_priority_queue #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.removed_value(removed_value),
		.status(status),
		.entry_count(entry_count)
	);

	always #5 clk = ~clk;

	function automatic outcome_t heap_apply(opcode_t op, key_t key);
		outcome_t r;
		int       idx;
		int       child;
		key_t     t;
		bit       done;
		r.removed = '0;
		r.st = ST_OK;
		done = 1'b0;
		if (op == OP_INSERT) begin
			if (heap_size >= CAPACITY) begin
				r.st = ST_FULL;
			end else begin
				heap_size++;
				heap_keys[heap_size] = key;
				idx = heap_size;
				while (idx > 1 && heap_keys[idx / 2] < heap_keys[idx]) begin
					t = heap_keys[idx / 2];
					heap_keys[idx / 2] = heap_keys[idx];
					heap_keys[idx] = t;
					idx = idx / 2;
				end
			end
		end else if (heap_size == 0) begin
			r.st = ST_EMPTY;
		end else begin
			r.removed = heap_keys[1];
			heap_keys[1] = heap_keys[heap_size];
			heap_size--;
			idx = 1;
			while (!done && 2 * idx <= heap_size) begin
				child = 2 * idx;
				if (child + 1 <= heap_size && heap_keys[child] < heap_keys[child + 1])
					child++;
				if (!(heap_keys[idx] < heap_keys[child])) begin
					done = 1'b1;
				end else begin
					t = heap_keys[idx];
					heap_keys[idx] = heap_keys[child];
					heap_keys[child] = t;
					idx = child;
				end
			end
		end
		r.count = heap_size[COUNT_OUT_W-1:0];
		return r;
	endfunction

	function automatic key_t pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 3)
			return int'($urandom_range(0, 8)) - 4;
		else if (sel == 3)
			return 32'sh7FFFFFFF;
		else if (sel == 4)
			return 32'sh80000000;
		else
			return $urandom;
	endfunction

	task automatic add_request(opcode_t op, key_t key, bit hold_until_idle, bit calm);
		request_t r;
		r.op = op;
		r.key = key;
		r.hold_until_idle = hold_until_idle;
		r.calm = calm;
		op_queue.push_back(r);
	endtask

	// fill past capacity, then drain past empty
	task automatic add_fill_drain(bit hold_until_idle, bit calm);
		for (int i = 0; i < CAPACITY + 2; i++)
			add_request(OP_INSERT, pick_key(), hold_until_idle && i == 0, calm);
		for (int i = 0; i < CAPACITY + 3; i++)
			add_request(OP_REMOVE, $urandom, 1'b0, calm);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= 1'b0;
			value <= '0;
			send_gap = 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (op_queue.size() == 0) begin
				in_valid <= 1'b0;
			end else if (op_queue[0].hold_until_idle &&
					(in_valid || out_valid || expected_outcomes.size() != 0)) begin
				in_valid <= 1'b0;
			end else if (!op_queue[0].calm && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(1, 15) - 1;
				in_valid <= 1'b0;
			end else begin
				next_req = op_queue.pop_front();
				in_valid <= 1'b1;
				opcode <= next_req.op;
				value <= next_req.key;
				calm_phase <= next_req.calm;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				recv_count++;
			// long hold-off so the block backs up and stalls its input
			if (!hold_done && recv_count >= 300) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(1, 15) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_outcomes.size() == 0) begin
					$error("unexpected result: removed_value %0d status %0d entry_count %0d",
						removed_value, status, entry_count);
					mismatch_count++;
				end else begin
					got_exp = expected_outcomes.pop_front();
					if (removed_value !== got_exp.removed) begin
						$error("removed_value: expected %0d, got %0d", got_exp.removed,
							removed_value);
						mismatch_count++;
					end
					if (status !== got_exp.st) begin
						$error("status: expected %0d, got %0d", got_exp.st, status);
						mismatch_count++;
					end
					if (entry_count !== got_exp.count) begin
						$error("entry_count: expected %0d, got %0d", got_exp.count,
							entry_count);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_outcomes.push_back(heap_apply(opcode_t'(opcode), value));
		end
	end

	initial begin
		int seg_len;
		int mode;
		int random_items;
		bit ins;

		// remove on empty, extreme keys, equal keys, drain past empty
		add_request(OP_REMOVE, 32'sh7FFFFFFF, 1'b0, 1'b0);
		add_request(OP_INSERT, 32'sh7FFFFFFF, 1'b0, 1'b0);
		add_request(OP_INSERT, 32'sh80000000, 1'b0, 1'b0);
		add_request(OP_INSERT, 32'sh00000000, 1'b0, 1'b0);
		add_request(OP_INSERT, -32'sd1, 1'b0, 1'b0);
		add_request(OP_INSERT, 32'sd5, 1'b0, 1'b0);
		add_request(OP_INSERT, 32'sd5, 1'b0, 1'b0);
		add_request(OP_INSERT, 32'sd5, 1'b0, 1'b0);
		for (int i = 0; i < 8; i++)
			add_request(OP_REMOVE, '0, 1'b0, 1'b0);
		add_request(OP_INSERT, 32'sh80000000, 1'b0, 1'b0);
		add_request(OP_INSERT, 32'sh80000000, 1'b0, 1'b0);
		add_request(OP_REMOVE, 32'sh55555555, 1'b0, 1'b0);
		add_request(OP_INSERT, 32'sh2AAAAAAA, 1'b0, 1'b0);
		add_request(OP_REMOVE, '1, 1'b0, 1'b0);
		add_request(OP_REMOVE, '0, 1'b0, 1'b0);
		add_request(OP_REMOVE, '0, 1'b0, 1'b0);

		// sender waits for the block to go idle before this one
		add_fill_drain(1'b1, 1'b0);

		random_items = 0;
		while (random_items < 1250) begin
			seg_len = $urandom_range(10, 80);
			mode = $urandom_range(0, 2);
			for (int i = 0; i < seg_len; i++) begin
				case (mode)
					0: ins = $urandom_range(0, 3) != 0;
					1: ins = $urandom_range(0, 3) == 0;
					default: ins = $urandom_range(0, 1) != 0;
				endcase
				add_request(ins ? OP_INSERT : OP_REMOVE, pick_key(), 1'b0, 1'b0);
			end
			random_items += seg_len;
		end

		// no idling from here on
		add_fill_drain(1'b0, 1'b1);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (op_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

### max_heap_priority_queue.f
rtl/mhpq_pkg.sv
rtl/mhpq_cell.sv
rtl/max_heap_priority_queue.sv
verif/max_heap_priority_queue_tb.sv
